/* rtl/core/s5udp_pkg.sv */
// Shared types and codes for the SOCKS5 UDP header parser.
// Holds wire address type codes and lengths, parser phases, role/kind/status codes and the state and result structs.
// No dependencies.
package s5udp_pkg;

  // Address type codes as carried on the wire
  localparam logic [7:0] ATYP_V4   = 8'd1;
  localparam logic [7:0] ATYP_NAME = 8'd3;
  localparam logic [7:0] ATYP_V6   = 8'd4;
  localparam logic [7:0] V4_BYTES  = 8'd4;
  localparam logic [7:0] V6_BYTES  = 8'd16;

  // Parser phases
  localparam logic [3:0] PH_RSV0    = 4'd0;
  localparam logic [3:0] PH_RSV1    = 4'd1;
  localparam logic [3:0] PH_FRAG    = 4'd2;
  localparam logic [3:0] PH_TYPE    = 4'd3;
  localparam logic [3:0] PH_DLEN    = 4'd4;
  localparam logic [3:0] PH_ADDR    = 4'd5;
  localparam logic [3:0] PH_PORTHI  = 4'd6;
  localparam logic [3:0] PH_PORTLO  = 4'd7;
  localparam logic [3:0] PH_PAYLOAD = 4'd8;

  // Byte roles
  localparam logic [1:0] ROLE_HDR     = 2'd0;
  localparam logic [1:0] ROLE_ADDR    = 2'd1;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
  localparam logic [1:0] ROLE_DROP    = 2'd3;

  // Address kinds as reported
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_V4   = 2'd1;
  localparam logic [1:0] KIND_NAME = 2'd2;
  localparam logic [1:0] KIND_V6   = 2'd3;

  // Frame status codes
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_HEADER = 3'd1;
  localparam logic [2:0] ERR_TYPE   = 3'd2;
  localparam logic [2:0] ERR_DLEN   = 3'd3;
  localparam logic [2:0] ERR_TRUNC  = 3'd4;
  localparam logic [2:0] ERR_PORT   = 3'd5;

  typedef struct packed {
    logic [3:0]  phase;
    logic [7:0]  bytes_left;
    logic [1:0]  kind;
    logic [7:0]  offset;
    logic [15:0] port;
    logic [2:0]  err;
  } s5udp_state_t;

  localparam s5udp_state_t STATE_RESET = '{
    phase:      PH_RSV0,
    bytes_left: 8'd0,
    kind:       KIND_NONE,
    offset:     8'd0,
    port:       16'd0,
    err:        ERR_NONE
  };

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  byte_role;
    logic [1:0]  address_kind;
    logic [7:0]  address_offset;
    logic [15:0] dest_port;
    logic [2:0]  frame_status;
    logic        frame_end;
  } s5udp_result_t;

endpackage

/* rtl/core/socks5_udp_header_parser.sv */
// Top level of the SOCKS5 UDP header parser: state and result registers.
// Instantiates s5udp_step; uses s5udp_pkg.

// One datagram byte is taken per cycle and gives exactly one tagged result word,
// in the cycle after acceptance, from an output register. The parser state advances
// through one shallow step per byte, so a word is taken in every cycle as long as
// the output register is empty or being drained in the same cycle; a stalled
// output holds the input off after one word. The verdict on frame_status is final
// on the word with frame_end set, and the parser starts the next datagram fresh
// on the following byte. No reset sweep is needed.
module socks5_udp_header_parser import s5udp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  byte_role_o,
  output logic [1:0]  address_kind_o,
  output logic [7:0]  address_offset_o,
  output logic [15:0] dest_port_o,
  output logic [2:0]  frame_status_o,
  output logic        frame_end_o
);

  s5udp_state_t  state_q, state_d;
  s5udp_result_t res_q, res_d;
  logic          out_valid_q;
  logic          in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  s5udp_step u_step (
    .state_i    (state_q),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .state_o    (state_d),
    .result_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // result word needs no reset, it is qualified by out_valid_q
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = res_q.out_byte;
  assign byte_role_o      = res_q.byte_role;
  assign address_kind_o   = res_q.address_kind;
  assign address_offset_o = res_q.address_offset;
  assign dest_port_o      = res_q.dest_port;
  assign frame_status_o   = res_q.frame_status;
  assign frame_end_o      = res_q.frame_end;

  // last word of a datagram always returns the parser to its start
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_byte_i) |=> (state_q == STATE_RESET))
    else $error("parser did not restart after last byte");

  // an error stays latched until the datagram ends
  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.err != ERR_NONE && !(in_fire && last_byte_i)) |=>
      (state_q.err == $past(state_q.err)))
    else $error("latched error changed mid-datagram");

  // offsets are reported only on address words
  a_offs_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_role_o != ROLE_ADDR) |-> (address_offset_o == 8'd0))
    else $error("nonzero offset on non-address word");

  // payload is only reached after a known address kind and a nonzero port
  a_payload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_role_o == ROLE_PAYLOAD) |->
      (address_kind_o != KIND_NONE && dest_port_o != 16'd0 &&
       frame_status_o == ERR_NONE))
    else $error("payload word without a valid header");

endmodule

/* rtl/core/s5udp_step.sv */
// Per-byte parser step: next state and tagged result for one input word.
// Purely combinational; uses s5udp_pkg.
module s5udp_step import s5udp_pkg::*; (
  input  s5udp_state_t  state_i,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  output s5udp_state_t  state_o,
  output s5udp_result_t result_o
);

  s5udp_state_t nxt;
  logic [1:0]   role;
  logic [7:0]   offs;
  logic [7:0]   port_lo;

  always_comb begin
    nxt     = state_i;
    role    = ROLE_HDR;
    offs    = 8'd0;
    port_lo = state_i.port[7:0] | data_byte_i;
    if (state_i.err != ERR_NONE) begin
      // drop everything until the end of the datagram
      role = ROLE_DROP;
    end else begin
      unique case (state_i.phase)
        PH_RSV0, PH_RSV1, PH_FRAG: begin
          if (data_byte_i != 8'd0) nxt.err = ERR_HEADER;
          else nxt.phase = 4'(state_i.phase + 4'd1);
        end
        PH_TYPE: begin
          priority if (data_byte_i == ATYP_V4) begin
            nxt.kind       = KIND_V4;
            nxt.bytes_left = V4_BYTES;
            nxt.phase      = PH_ADDR;
          end else if (data_byte_i == ATYP_V6) begin
            nxt.kind       = KIND_V6;
            nxt.bytes_left = V6_BYTES;
            nxt.phase      = PH_ADDR;
          end else if (data_byte_i == ATYP_NAME) begin
            nxt.kind  = KIND_NAME;
            nxt.phase = PH_DLEN;
          end else begin
            nxt.err = ERR_TYPE;
          end
        end
        PH_DLEN: begin
          if (data_byte_i == 8'd0) begin
            nxt.err = ERR_DLEN;
          end else begin
            nxt.bytes_left = data_byte_i;
            nxt.phase      = PH_ADDR;
          end
        end
        PH_ADDR: begin
          role           = ROLE_ADDR;
          offs           = state_i.offset;
          nxt.offset     = 8'(state_i.offset + 8'd1);
          nxt.bytes_left = 8'(state_i.bytes_left - 8'd1);
          if (nxt.bytes_left == 8'd0) nxt.phase = PH_PORTHI;
        end
        PH_PORTHI: begin
          nxt.port  = {data_byte_i, 8'd0};
          nxt.phase = PH_PORTLO;
        end
        PH_PORTLO: begin
          nxt.port = {state_i.port[15:8], port_lo};
          if ({state_i.port[15:8], port_lo} == 16'd0) nxt.err = ERR_PORT;
          else nxt.phase = PH_PAYLOAD;
        end
        default: begin
          role = ROLE_PAYLOAD;
        end
      endcase
      // an error raised by this word wins over truncation
      if (last_byte_i && nxt.err == ERR_NONE && nxt.phase != PH_PAYLOAD) begin
        nxt.err = ERR_TRUNC;
      end
    end
  end

  assign result_o = '{
    out_byte:       data_byte_i,
    byte_role:      role,
    address_kind:   nxt.kind,
    address_offset: offs,
    dest_port:      nxt.port,
    frame_status:   nxt.err,
    frame_end:      last_byte_i
  };

  // start over after the last word of a datagram
  assign state_o = last_byte_i ? STATE_RESET : nxt;

endmodule
